// ----- hdl/wbcs_pkg.sv -----
// ----------------------------------------------------------------------------
// wbcs_pkg
// Shared widths, constants, codes and types of the white blob centroid
// steering block.
// ----------------------------------------------------------------------------
package wbcs_pkg;

   // field and state widths
   localparam int ROW_W      = 13;
   localparam int COL_W      = 12;
   localparam int PIX_W      = 8;
   localparam int WC_W       = 23;
   localparam int MOM_W      = 35;
   localparam int OFF_W      = 14;
   localparam int SC_W       = 6;
   localparam int LIN_W      = 9;
   localparam int ANG_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int DIV_CNT_W  = 6;

   // row length limits
   localparam logic [ROW_W-1:0] MIN_ROW = 13'd2;
   localparam logic [ROW_W-1:0] MAX_ROW = 13'd4096;

   // register reset values
   localparam logic [ROW_W-1:0] ROW_BYTES_RST   = 13'd2400;
   localparam logic [PIX_W-1:0] WHITE_LEVEL_RST = 8'd255;
   localparam logic [7:0]       MIN_WHITE_RST   = 8'd5;
   localparam logic [SC_W-1:0]  LEFT_RST        = 6'd20;
   localparam logic [SC_W-1:0]  RIGHT_RST       = 6'd40;

   // accumulator limits
   localparam logic [WC_W-1:0] WHITE_MAX = {WC_W{1'b1}};
   localparam logic signed [MOM_W-1:0] MOMENT_MAX = {1'b0, {(MOM_W-1){1'b1}}};
   localparam logic signed [MOM_W-1:0] MOMENT_MIN = {1'b1, {(MOM_W-1){1'b0}}};

   // drive commands in thousandths
   localparam logic signed [LIN_W-1:0] LIN_FWD   = 9'sd100;
   localparam logic signed [LIN_W-1:0] LIN_STOP  = 9'sd0;
   localparam logic signed [LIN_W-1:0] LIN_REV   = -9'sd200;
   localparam logic signed [ANG_W-1:0] ANG_LEFT  = 13'sd500;
   localparam logic signed [ANG_W-1:0] ANG_RIGHT = -13'sd500;
   localparam logic signed [ANG_W-1:0] ANG_ZERO  = 13'sd0;
   localparam logic [ANG_W-1:0]        TURN_LIMIT = 13'd2048;

   // one quotient bit per step over the whole moment magnitude
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(MOM_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_BYTES    = 3'd0,
      CSR_WHITE_LEVEL  = 3'd1,
      CSR_MIN_WHITE    = 3'd2,
      CSR_LEFT_FRAMES  = 3'd3,
      CSR_RIGHT_FRAMES = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_bytes;
      logic [PIX_W-1:0] white_level;
      logic [7:0]       min_white_count;
      logic [SC_W-1:0]  left_search_frames;
      logic [SC_W-1:0]  right_search_frames;
   } csr_type;

   typedef struct packed {
      logic [WC_W-1:0]         white_count;
      logic signed [MOM_W-1:0] moment;
   } frame_stat_type;

   typedef struct packed {
      logic             start;
      logic [MOM_W-1:0] magnitude;
      logic [WC_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [MOM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- hdl/wbcs_req_if.sv -----
// ----------------------------------------------------------------------------
// wbcs_req_if
// Pixel request channel: valid/ready handshake with one image byte.
// ----------------------------------------------------------------------------
interface wbcs_req_if;
   logic                      valid;
   logic                      ready;
   logic [wbcs_pkg::PIX_W-1:0] pixel_byte;
   logic                      end_of_frame;

   modport source (output valid, output pixel_byte, output end_of_frame, input ready);
   modport sink   (input valid, input pixel_byte, input end_of_frame, output ready);
endinterface

// ----- hdl/wbcs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wbcs_rsp_if
// Drive command channel: valid/ready handshake with one steering command.
// ----------------------------------------------------------------------------
interface wbcs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [wbcs_pkg::LIN_W-1:0] linear_speed_milli;
   logic signed [wbcs_pkg::ANG_W-1:0] angular_rate_milli;
   logic                              target_found;

   modport source (output valid, output linear_speed_milli, output angular_rate_milli,
                   output target_found, input ready);
   modport sink   (input valid, input linear_speed_milli, input angular_rate_milli,
                   input target_found, output ready);
endinterface

// ----- hdl/wbcs_accum.sv -----
// ----------------------------------------------------------------------------
// wbcs_accum
// Frame accumulators: column tracking, white byte count and signed column
// moment, both saturating.
// ----------------------------------------------------------------------------
module wbcs_accum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [wbcs_pkg::PIX_W-1:0]     pixel_byte,
   input  logic                           end_of_frame,
   input  wbcs_pkg::csr_type              csr,
   output wbcs_pkg::frame_stat_type       stat
);

   logic [wbcs_pkg::ROW_W-1:0]         row_len;
   logic [wbcs_pkg::COL_W-1:0]         half_len;
   logic signed [wbcs_pkg::OFF_W-1:0]  offset;
   logic                               is_white;
   logic signed [wbcs_pkg::MOM_W:0]    sum;
   logic [wbcs_pkg::ROW_W-1:0]         col_inc;

   logic [wbcs_pkg::COL_W-1:0]         col_ff, col_in;
   logic [wbcs_pkg::WC_W-1:0]          wc_ff, wc_in;
   logic signed [wbcs_pkg::MOM_W-1:0]  mom_ff, mom_in;

   // clamp the row length into its legal range
   always_comb begin
      if (csr.row_bytes < wbcs_pkg::MIN_ROW) begin
         row_len = wbcs_pkg::MIN_ROW;
      end else if (csr.row_bytes > wbcs_pkg::MAX_ROW) begin
         row_len = wbcs_pkg::MAX_ROW;
      end else begin
         row_len = csr.row_bytes;
      end
   end

   assign half_len = row_len[wbcs_pkg::ROW_W-1:1];
   assign offset   = $signed({2'b00, col_ff}) - $signed({2'b00, half_len});
   assign is_white = (pixel_byte == csr.white_level);
   assign sum      = (wbcs_pkg::MOM_W+1)'(mom_ff) + (wbcs_pkg::MOM_W+1)'(offset);
   assign col_inc  = {1'b0, col_ff} + 13'd1;

   // update the counts with the current byte
   always_comb begin
      stat.white_count = wc_ff;
      stat.moment      = mom_ff;
      if (is_white) begin
         if (wc_ff != wbcs_pkg::WHITE_MAX) begin
            stat.white_count = wc_ff + 1'b1;
         end
         case (sum[wbcs_pkg::MOM_W:wbcs_pkg::MOM_W-1])
            2'b01:   stat.moment = wbcs_pkg::MOMENT_MAX;
            2'b10:   stat.moment = wbcs_pkg::MOMENT_MIN;
            default: stat.moment = sum[wbcs_pkg::MOM_W-1:0];
         endcase
      end
   end

   // advance the column, clear everything at frame end
   always_comb begin
      col_in = col_ff;
      wc_in  = wc_ff;
      mom_in = mom_ff;
      if (accept) begin
         if (end_of_frame) begin
            col_in = '0;
            wc_in  = '0;
            mom_in = '0;
         end else begin
            col_in = (col_inc >= row_len) ? '0 : col_inc[wbcs_pkg::COL_W-1:0];
            wc_in  = stat.white_count;
            mom_in = stat.moment;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         wc_ff  <= '0;
         mom_ff <= '0;
      end else begin
         col_ff <= col_in;
         wc_ff  <= wc_in;
         mom_ff <= mom_in;
      end
   end

endmodule

// ----- hdl/wbcs_divider.sv -----
// ----------------------------------------------------------------------------
// wbcs_divider
// Restoring divider: one quotient bit per cycle, moment magnitude over the
// white count.
// ----------------------------------------------------------------------------
module wbcs_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  wbcs_pkg::div_cmd_type cmd,
   output wbcs_pkg::div_rsp_type rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [wbcs_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [wbcs_pkg::WC_W-1:0]        rem_ff, rem_in;
   logic [wbcs_pkg::MOM_W-1:0]       quo_ff, quo_in;
   logic [wbcs_pkg::WC_W-1:0]        dsr_ff, dsr_in;

   logic [wbcs_pkg::WC_W:0]          trial;
   logic [wbcs_pkg::WC_W:0]          diff;
   logic                             fits;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, quo_ff[wbcs_pkg::MOM_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = cmd.magnitude;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[wbcs_pkg::WC_W-1:0] : trial[wbcs_pkg::WC_W-1:0];
         quo_in = {quo_ff[wbcs_pkg::MOM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == wbcs_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- hdl/wbcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// wbcs_ctrl
// Frame-end sequencer: search counter, command selection, divider launch and
// the registered command output.
// ----------------------------------------------------------------------------
module wbcs_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  wbcs_pkg::csr_type                 csr,
   input  logic                              req_accept,
   input  logic                              req_eof,
   input  wbcs_pkg::frame_stat_type          stat,
   output logic                              req_ready,
   output wbcs_pkg::div_cmd_type             div_cmd,
   input  wbcs_pkg::div_rsp_type             div_rsp,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic signed [wbcs_pkg::LIN_W-1:0] rsp_lin,
   output logic signed [wbcs_pkg::ANG_W-1:0] rsp_ang,
   output logic                              rsp_found
);

   wbcs_pkg::state_type                state_ff, state_in;
   logic [wbcs_pkg::SC_W-1:0]          sc_ff, sc_in;
   logic                               neg_ff;
   logic signed [wbcs_pkg::LIN_W-1:0]  pend_lin_ff;
   logic signed [wbcs_pkg::ANG_W-1:0]  pend_ang_ff;
   logic                               pend_found_ff;
   logic                               rsp_valid_ff;
   logic signed [wbcs_pkg::LIN_W-1:0]  rsp_lin_ff;
   logic signed [wbcs_pkg::ANG_W-1:0]  rsp_ang_ff;
   logic                               rsp_found_ff;

   logic                               eof_take;
   logic                               found;
   logic                               need_div;
   logic [wbcs_pkg::SC_W-1:0]          sc_step;
   logic                               load_out;
   logic [wbcs_pkg::ANG_W-1:0]         clip_mag;
   logic signed [wbcs_pkg::ANG_W-1:0]  ang_div;

   assign eof_take = req_accept && req_eof;
   assign found    = (stat.white_count >= {15'd0, csr.min_white_count});
   assign need_div = found && (stat.white_count != '0);
   assign sc_step  = sc_ff + 1'b1;

   // turn is minus the mean, clipped to the turn limit
   assign clip_mag = (div_rsp.quotient > 35'(wbcs_pkg::TURN_LIMIT)) ?
                     wbcs_pkg::TURN_LIMIT : div_rsp.quotient[wbcs_pkg::ANG_W-1:0];
   assign ang_div  = neg_ff ? $signed(clip_mag) : -$signed(clip_mag);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wbcs_pkg::ST_IDLE: begin
            if (eof_take) begin
               state_in = need_div ? wbcs_pkg::ST_DIV : wbcs_pkg::ST_DONE;
            end
         end
         wbcs_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = wbcs_pkg::ST_DONE;
            end
         end
         wbcs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = wbcs_pkg::ST_IDLE;
            end
         end
         default: state_in = wbcs_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         wbcs_pkg::ST_IDLE: req_ready = 1'b1;
         wbcs_pkg::ST_DIV:  req_ready = 1'b0;
         wbcs_pkg::ST_DONE: load_out  = !rsp_valid_ff || rsp_ready;
         default:           req_ready = 1'b0;
      endcase
   end

   assign div_cmd.start     = eof_take && need_div;
   assign div_cmd.magnitude = stat.moment[wbcs_pkg::MOM_W-1] ?
                              wbcs_pkg::MOM_W'(-stat.moment) : stat.moment;
   assign div_cmd.divisor   = stat.white_count;

   // search counter steps on frames without a target and clears on a target or a reverse
   always_comb begin
      sc_in = sc_ff;
      if (eof_take) begin
         if (found || (sc_step >= csr.right_search_frames &&
                       sc_step >= csr.left_search_frames)) begin
            sc_in = '0;
         end else begin
            sc_in = sc_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wbcs_pkg::ST_IDLE;
         sc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sc_ff    <= sc_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pick the pending command, fill in the turn once the divider is done
   always_ff @(posedge clock) begin
      if (eof_take) begin
         neg_ff        <= stat.moment[wbcs_pkg::MOM_W-1];
         pend_found_ff <= found;
         if (found) begin
            pend_lin_ff <= wbcs_pkg::LIN_FWD;
            pend_ang_ff <= wbcs_pkg::ANG_ZERO;
         end else if (sc_step < csr.left_search_frames) begin
            pend_lin_ff <= wbcs_pkg::LIN_STOP;
            pend_ang_ff <= wbcs_pkg::ANG_LEFT;
         end else if (sc_step < csr.right_search_frames) begin
            pend_lin_ff <= wbcs_pkg::LIN_STOP;
            pend_ang_ff <= wbcs_pkg::ANG_RIGHT;
         end else begin
            pend_lin_ff <= wbcs_pkg::LIN_REV;
            pend_ang_ff <= wbcs_pkg::ANG_ZERO;
         end
      end else if (state_ff == wbcs_pkg::ST_DIV && div_rsp.done) begin
         pend_ang_ff <= ang_div;
      end
      if (load_out) begin
         rsp_lin_ff   <= pend_lin_ff;
         rsp_ang_ff   <= pend_ang_ff;
         rsp_found_ff <= pend_found_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lin   = rsp_lin_ff;
   assign rsp_ang   = rsp_ang_ff;
   assign rsp_found = rsp_found_ff;

endmodule

// ----- hdl/white_blob_centroid_steering.sv -----
// A frame-end request without a target (or with a zero white count) goes straight to
// the done state; otherwise the divider first takes 35 steps, one quotient bit each.
// Throughput: one byte per cycle inside a frame; after the frame-end byte the
// block takes no request until the command is in the output register.
// Reset (synchronous, active high) restores the register defaults, clears the
// accumulators, the search counter and the output valid.
// ----------------------------------------------------------------------------
// white_blob_centroid_steering
// Tracks the white byte centroid of each frame and emits one drive command
// at every frame end.
// ----------------------------------------------------------------------------
module white_blob_centroid_steering (
   input  logic                              clock,
   input  logic                              reset,
   wbcs_req_if.sink                          req_chan,
   wbcs_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [wbcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wbcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   wbcs_pkg::csr_type        csr_ff, csr_in;
   wbcs_pkg::frame_stat_type stat;
   wbcs_pkg::div_cmd_type    div_cmd;
   wbcs_pkg::div_rsp_type    div_rsp;
   logic                     req_accept;

   // register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            wbcs_pkg::CSR_ROW_BYTES:    csr_in.row_bytes = csr_wdata;
            wbcs_pkg::CSR_WHITE_LEVEL:  csr_in.white_level = csr_wdata[7:0];
            wbcs_pkg::CSR_MIN_WHITE:    csr_in.min_white_count = csr_wdata[7:0];
            wbcs_pkg::CSR_LEFT_FRAMES:  csr_in.left_search_frames = csr_wdata[5:0];
            wbcs_pkg::CSR_RIGHT_FRAMES: csr_in.right_search_frames = csr_wdata[5:0];
            default:                    csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.row_bytes           <= wbcs_pkg::ROW_BYTES_RST;
         csr_ff.white_level         <= wbcs_pkg::WHITE_LEVEL_RST;
         csr_ff.min_white_count     <= wbcs_pkg::MIN_WHITE_RST;
         csr_ff.left_search_frames  <= wbcs_pkg::LEFT_RST;
         csr_ff.right_search_frames <= wbcs_pkg::RIGHT_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign req_accept = req_chan.valid && req_chan.ready;

   wbcs_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .pixel_byte   (req_chan.pixel_byte),
      .end_of_frame (req_chan.end_of_frame),
      .csr          (csr_ff),
      .stat         (stat)
   );

   wbcs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   wbcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .req_accept (req_accept),
      .req_eof    (req_chan.end_of_frame),
      .stat       (stat),
      .req_ready  (req_chan.ready),
      .div_cmd    (div_cmd),
      .div_rsp    (div_rsp),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_lin    (rsp_chan.linear_speed_milli),
      .rsp_ang    (rsp_chan.angular_rate_milli),
      .rsp_found  (rsp_chan.target_found)
   );

endmodule

// ----- hdl/wbcs_checker.sv -----
// ----------------------------------------------------------------------------
// wbcs_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module wbcs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_eof,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [wbcs_pkg::LIN_W-1:0] lin,
   input logic signed [wbcs_pkg::ANG_W-1:0] ang,
   input logic                              found
);

   // a frame end stalls the request side in the cycle after it
   a_eof_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_eof) |=> !req_ready)
      else $error("request accepted right after a frame end");

   // hold a stalled command
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("command dropped while stalled");

   // drop the command on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("command valid after reset");

   // a found target drives forward within the turn limit
   a_found_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && found) |-> (lin == wbcs_pkg::LIN_FWD &&
                                ang >= -13'sd2048 && ang <= 13'sd2048))
      else $error("bad command for a found target");

   // a search step is a left turn, a right turn or a reverse
   a_search_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !found) |->
         ((lin == wbcs_pkg::LIN_STOP &&
           (ang == wbcs_pkg::ANG_LEFT || ang == wbcs_pkg::ANG_RIGHT)) ||
          (lin == wbcs_pkg::LIN_REV && ang == wbcs_pkg::ANG_ZERO)))
      else $error("bad search command");

endmodule

bind white_blob_centroid_steering wbcs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_eof   (req_chan.end_of_frame),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .lin       (rsp_chan.linear_speed_milli),
   .ang       (rsp_chan.angular_rate_milli),
   .found     (rsp_chan.target_found)
);

// ----- sim/white_blob_centroid_steering_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// white_blob_centroid_steering_tb
// Streams image bytes into the steering block under random gaps and output
// stalls. A local predictor keeps its own copy of the registers, the frame
// accumulators and the search counter, and every drive command is compared
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module white_blob_centroid_steering_tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 48;
   localparam int RANDOM_ITEMS = 600;
   localparam int MAX_REPORTS  = 10;

   localparam longint MOM_HI = 64'sd17179869183;
   localparam longint MOM_LO = -64'sd17179869184;
   localparam logic [22:0] WC_SAT = 23'h7FFFFF;

   typedef struct packed {
      logic signed [wbcs_pkg::LIN_W-1:0] lin;
      logic signed [wbcs_pkg::ANG_W-1:0] ang;
      logic                              found;
   } drive_cmd_type;

   logic clock;
   logic reset;
   logic                            csr_wr_en;
   wbcs_pkg::csr_index_type         csr_index;
   logic [wbcs_pkg::CSR_DATA_W-1:0] csr_wdata;

   wbcs_req_if req_bus ();
   wbcs_rsp_if rsp_bus ();

   white_blob_centroid_steering u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers
   logic [12:0] cfg_row;
   logic [7:0]  cfg_white;
   logic [7:0]  cfg_min;
   logic [5:0]  cfg_left;
   logic [5:0]  cfg_right;

   // predictor copy of the frame and search state
   logic [11:0] col_pos;
   logic [22:0] white_cnt;
   longint      col_moment;
   logic [5:0]  search_cnt;

   drive_cmd_type pending_cmds[$];
   drive_cmd_type cmd_want;
   int         error_count;
   int         rsp_count;
   int         cycle_count;
   int         burst_left;
   int         random_items;

   // stall controls shared with the receiver
   bit tx_idle_en;
   bit rx_open;
   int hold_len;
   int hold_token;
   int rx_hold_seen;
   int rx_hold_left;
   int rx_tick;
   logic [15:0] rx_pattern;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the predicted state by one request; return 1 when a command is due.
   function automatic bit predict_drive_cmd(input logic [7:0] pix, input logic eof,
                                            output drive_cmd_type cmd);
      int     len;
      longint off;
      longint mean;
      longint ang;
      bit     found;
      len = int'(cfg_row);
      if (len < 2) len = 2;
      if (len > 4096) len = 4096;
      cmd = '0;
      // accumulate a white byte's offset from mid-row
      if (pix == cfg_white) begin
         off = longint'(col_pos) - longint'(len / 2);
         if (white_cnt != WC_SAT) white_cnt = white_cnt + 23'd1;
         col_moment = col_moment + off;
         if (col_moment > MOM_HI) col_moment = MOM_HI;
         if (col_moment < MOM_LO) col_moment = MOM_LO;
      end
      // wrap the column at the row end, also when the row shrank under it
      if (int'(col_pos) + 1 >= len) col_pos = '0;
      else col_pos = col_pos + 12'd1;
      if (!eof) return 1'b0;
      found = (white_cnt >= 23'(cfg_min));
      if (found) begin
         mean = 0;
         if (white_cnt != '0) mean = col_moment / longint'(white_cnt);
         ang = -mean;
         if (ang > 2048) ang = 2048;
         if (ang < -2048) ang = -2048;
         cmd.lin = 9'sd100;
         cmd.ang = ang[wbcs_pkg::ANG_W-1:0];
         search_cnt = '0;
      end else begin
         // step the search, then pick left, right or reverse
         search_cnt = search_cnt + 6'd1;
         if (search_cnt < cfg_left) begin
            cmd.lin = 9'sd0;
            cmd.ang = 13'sd500;
         end else if (search_cnt < cfg_right) begin
            cmd.lin = 9'sd0;
            cmd.ang = -13'sd500;
         end else begin
            cmd.lin = -9'sd200;
            cmd.ang = 13'sd0;
            search_cnt = '0;
         end
      end
      cmd.found = found;
      col_pos    = '0;
      white_cnt  = '0;
      col_moment = 0;
      return 1'b1;
   endfunction

   task automatic flag_error(input string msg);
      if (error_count < MAX_REPORTS) $display("mismatch: %s", msg);
      error_count++;
   endtask

   // Offer one request in bursts with random gaps, then predict its command.
   task automatic push_pixel(input logic [7:0] pix, input logic eof);
      int            gap;
      drive_cmd_type cmd;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = tx_idle_en ? $urandom_range(1, 8) : 0;
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.pixel_byte   <= pix;
      req_bus.end_of_frame <= eof;
      do @(posedge clock); while (!req_bus.ready);
      if (predict_drive_cmd(pix, eof, cmd)) pending_cmds.push_back(cmd);
   endtask

   // Send a frame of n bytes, white with the given percentage.
   task automatic push_frame(input int n, input int white_pct);
      logic [7:0] pix;
      for (int i = 0; i < n; i++) begin
         pix = ($urandom_range(0, 99) < white_pct) ? cfg_white : 8'($urandom);
         push_pixel(pix, i == n - 1);
      end
   endtask

   // Drop valid, wait for every command, then let the divider finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input wbcs_pkg::csr_index_type idx,
                            input logic [wbcs_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         wbcs_pkg::CSR_ROW_BYTES:    cfg_row   = data;
         wbcs_pkg::CSR_WHITE_LEVEL:  cfg_white = data[7:0];
         wbcs_pkg::CSR_MIN_WHITE:    cfg_min   = data[7:0];
         wbcs_pkg::CSR_LEFT_FRAMES:  cfg_left  = data[5:0];
         wbcs_pkg::CSR_RIGHT_FRAMES: cfg_right = data[5:0];
         default: ;
      endcase
   endtask

   // Register values right after reset, never written.
   task automatic test_reset_defaults();
      tx_idle_en = 1'b1;
      rx_open    = 1'b0;
      push_frame(6, 100);
      push_frame(4, 100);
      push_frame(12, 50);
      push_frame(1, 0);
   endtask

   // Field extremes, row clamps, zero minimum, truncation and every search step.
   task automatic test_directed();
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd0);
      write_csr(wbcs_pkg::CSR_WHITE_LEVEL, {5'h1F, 8'd0});
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd1);
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd1);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd63);
      // mean of -2/3 truncates to zero
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd0, 1'b1);
      push_pixel(8'hFF, 1'b1);
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd1);
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd0);
      // no white byte, yet found with a zero minimum
      push_pixel(8'hFF, 1'b1);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'h80, 1'b1);
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'h1FFF);
      write_csr(wbcs_pkg::CSR_WHITE_LEVEL, {5'h1F, 8'hFF});
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd255);
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd0);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd0);
      push_pixel(8'hFF, 1'b1);
      settle();
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd1);
      // column 0 of the widest row gives the largest left turn
      push_pixel(8'hFF, 1'b1);
      settle();
      write_csr(wbcs_pkg::CSR_MIN_WHITE, {5'h1F, 8'd255});
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'h1FFF);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, {7'h7F, 6'd0});
      push_pixel(8'h7F, 1'b1);
      push_pixel(8'h01, 1'b1);
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd3);
      write_csr(wbcs_pkg::CSR_WHITE_LEVEL, 13'hAA);
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd2);
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd1);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd3);
      push_pixel(8'hAA, 1'b0);
      push_pixel(8'hAA, 1'b0);
      push_pixel(8'hAA, 1'b0);
      push_pixel(8'hAA, 1'b1);
      push_pixel(8'h55, 1'b1);
      push_pixel(8'hAA, 1'b1);
      push_pixel(8'h00, 1'b1);
   endtask

   // Change the row length in the middle of a row.
   task automatic test_row_shrink();
      settle();
      tx_idle_en = 1'b1;
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd16);
      write_csr(wbcs_pkg::CSR_WHITE_LEVEL, 13'd50);
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd1);
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd2);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd4);
      for (int i = 0; i < 10; i++)
         push_pixel((i % 3 == 0) ? cfg_white : 8'(50 + 1 + $urandom_range(0, 200)), 1'b0);
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd4);
      for (int i = 0; i < 5; i++) push_pixel(cfg_white, 1'b0);
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd64);
      for (int i = 0; i < 6; i++) push_pixel(cfg_white, i == 5);
      push_frame(3, 0);
   endtask

   // Walk the search counter to its top and through crossed thresholds.
   task automatic test_search_walk();
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd5);
      write_csr(wbcs_pkg::CSR_WHITE_LEVEL, 13'd9);
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd3);
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd63);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd63);
      repeat (66) push_frame($urandom_range(1, 3), 0);
      settle();
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd10);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd5);
      repeat (14) push_frame($urandom_range(1, 3), 0);
      settle();
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd3);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd6);
      repeat (10) push_frame($urandom_range(1, 3), 10);
   endtask

   // Largest minimum: frames right at and just below 255 white bytes.
   task automatic test_dense_min();
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd32);
      write_csr(wbcs_pkg::CSR_WHITE_LEVEL, 13'd255);
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd255);
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd2);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd4);
      push_frame(255, 100);
      push_frame(254, 100);
   endtask

   // Hold the receiver off while the sender keeps offering frames.
   task automatic test_backpressure();
      settle();
      write_csr(wbcs_pkg::CSR_ROW_BYTES, 13'd8);
      write_csr(wbcs_pkg::CSR_WHITE_LEVEL, 13'h33);
      write_csr(wbcs_pkg::CSR_MIN_WHITE, 13'd2);
      write_csr(wbcs_pkg::CSR_LEFT_FRAMES, 13'd3);
      write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, 13'd5);
      tx_idle_en = 1'b0;
      rx_open    = 1'b0;
      hold_len   = 400;
      hold_token++;
      repeat (12) push_frame(4, 70);
      tx_idle_en = 1'b1;
   endtask

   // Random settings per phase, random frames within.
   task automatic test_random_frames();
      logic [12:0] row;
      logic [7:0]  level;
      logic [7:0]  min_cnt;
      logic [5:0]  lft;
      logic [5:0]  rgt;
      int          n;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle();
         tx_idle_en = ($urandom_range(0, 3) != 0);
         rx_open    = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0: row = 13'($urandom_range(0, 3));
            1: row = $urandom_range(0, 1) ? 13'h1FFF : 13'($urandom_range(4090, 4100));
            default: row = 13'($urandom_range(2, 24));
         endcase
         case ($urandom_range(0, 3))
            0: level = 8'd0;
            1: level = 8'd255;
            default: level = 8'($urandom);
         endcase
         min_cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
         lft = ($urandom_range(0, 5) == 0) ? 6'd63 : 6'($urandom_range(0, 8));
         rgt = ($urandom_range(0, 5) == 0) ? 6'd63 : 6'($urandom_range(0, 8));
         write_csr(wbcs_pkg::CSR_ROW_BYTES, row);
         write_csr(wbcs_pkg::CSR_WHITE_LEVEL, {5'($urandom), level});
         write_csr(wbcs_pkg::CSR_MIN_WHITE, {5'($urandom), min_cnt});
         write_csr(wbcs_pkg::CSR_LEFT_FRAMES, {7'($urandom), lft});
         write_csr(wbcs_pkg::CSR_RIGHT_FRAMES, {7'($urandom), rgt});
         repeat ($urandom_range(4, 12)) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
            push_frame(n, $urandom_range(0, 100));
            random_items += n;
         end
      end
   endtask

   // Receiver: own stall pattern, optional open stretches and long hold-offs.
   always @(posedge clock) begin
      if (hold_token != rx_hold_seen) begin
         rx_hold_seen = hold_token;
         rx_hold_left = hold_len;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rx_open) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= rx_pattern[0];
      end
      if (rx_tick == 0) rx_pattern = 16'($urandom) | 16'($urandom);
      else rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
      rx_tick = (rx_tick + 1) % 64;
   end

   // Compare each accepted command with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_cmds.size() == 0) begin
            flag_error($sformatf("command %0d arrived with none predicted", rsp_count));
         end else begin
            cmd_want = pending_cmds.pop_front();
            if (rsp_bus.linear_speed_milli !== cmd_want.lin ||
                rsp_bus.angular_rate_milli !== cmd_want.ang ||
                rsp_bus.target_found !== cmd_want.found)
               flag_error($sformatf({"command %0d: expected lin %0d ang %0d found %0b,",
                                     " got lin %0d ang %0d found %0b"},
                                    rsp_count, cmd_want.lin, cmd_want.ang, cmd_want.found,
                                    rsp_bus.linear_speed_milli, rsp_bus.angular_rate_milli,
                                    rsp_bus.target_found));
         end
         rsp_count++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = wbcs_pkg::CSR_ROW_BYTES;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.pixel_byte   = '0;
      req_bus.end_of_frame = 1'b0;
      rsp_bus.ready        = 1'b0;
      error_count  = 0;
      rsp_count    = 0;
      cycle_count  = 0;
      burst_left   = 0;
      hold_len     = 0;
      hold_token   = 0;
      rx_hold_seen = 0;
      rx_hold_left = 0;
      rx_tick      = 0;
      rx_pattern   = 16'hFFFF;
      tx_idle_en   = 1'b1;
      rx_open      = 1'b0;
      // register defaults and cleared state, as after reset
      cfg_row    = 13'd2400;
      cfg_white  = 8'd255;
      cfg_min    = 8'd5;
      cfg_left   = 6'd20;
      cfg_right  = 6'd40;
      col_pos    = '0;
      white_cnt  = '0;
      col_moment = 0;
      search_cnt = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed();
      test_row_shrink();
      test_search_walk();
      test_dense_min();
      test_backpressure();
      test_random_frames();
      settle();

      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- white_blob_centroid_steering.f -----
hdl/wbcs_pkg.sv
hdl/wbcs_req_if.sv
hdl/wbcs_rsp_if.sv
hdl/wbcs_accum.sv
hdl/wbcs_divider.sv
hdl/wbcs_ctrl.sv
hdl/white_blob_centroid_steering.sv
hdl/wbcs_checker.sv
sim/white_blob_centroid_steering_tb.sv
